/* src/smbrc_pkg.sv */
// Shared types, codes and the CRC-8 helper for the SMBus read response checker.
`default_nettype none
package smbrc_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_READ_MODE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DEVICE_ADDR = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_COMMAND     = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_LENGTH  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_MA_ADDRESS  = 3'd4;

   localparam logic [1:0] MODE_WORD  = 2'd0;
   localparam logic [1:0] MODE_BLOCK = 2'd1;
   localparam logic [1:0] MODE_MA    = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd1;
   localparam logic [2:0] STATUS_PEC_ERR   = 3'd2;
   localparam logic [2:0] STATUS_ADDR_ERR  = 3'd3;
   localparam logic [2:0] STATUS_TOO_SHORT = 3'd4;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [7:0] CRC_POLY = 8'h07;

   typedef struct packed {
      logic [1:0]  read_mode;
      logic [7:0]  device_address;
      logic [7:0]  command_code;
      logic [5:0]  max_length;
      logic [15:0] expected_ma_address;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic [2:0] status;
      logic [5:0] payload_count;
   } rsp_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* src/smbrc_csr.sv */
// Configuration registers of the SMBus read response checker.
`default_nettype none
module smbrc_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [smbrc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [smbrc_pkg::CsrDataWidth-1:0]   csr_wdata,
   output smbrc_pkg::cfg_type                        cfg
);

   smbrc_pkg::cfg_type cfg_ff;
   smbrc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            smbrc_pkg::CSR_READ_MODE:   cfg_in.read_mode           = csr_wdata[1:0];
            smbrc_pkg::CSR_DEVICE_ADDR: cfg_in.device_address      = csr_wdata[7:0];
            smbrc_pkg::CSR_COMMAND:     cfg_in.command_code        = csr_wdata[7:0];
            smbrc_pkg::CSR_MAX_LENGTH:  cfg_in.max_length          = csr_wdata[5:0];
            smbrc_pkg::CSR_MA_ADDRESS:  cfg_in.expected_ma_address = csr_wdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_mode           <= smbrc_pkg::MODE_BLOCK;
         cfg_ff.device_address      <= 8'd22;
         cfg_ff.command_code        <= 8'd0;
         cfg_ff.max_length          <= 6'd32;
         cfg_ff.expected_ma_address <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/smbrc_core.sv */
// Input register, response state and per-byte checking logic.
`default_nettype none
module smbrc_core #(
   parameter int unsigned MAX_BLOCK = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire smbrc_pkg::cfg_type cfg,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_byte,
   input  wire logic               req_first,
   input  wire logic               out_free,
   output logic                    res_valid,
   output smbrc_pkg::rsp_type      res
);

   localparam logic [5:0] MaxBlk = 6'(MAX_BLOCK);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;

   logic [5:0] pos_ff, pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [5:0] len_ff, len_in;
   logic [7:0] low_ff, low_in;
   logic       bad_ff, bad_in;
   logic       done_ff, done_in;

   logic       fire;
   logic       emit;
   logic [7:0] seed_crc;
   logic [7:0] cur_crc, crc_upd;
   logic [5:0] cur_pos, cur_len, limit, delivered;
   logic [7:0] cur_low;
   logic       cur_bad, cur_done, is_ma;
   smbrc_pkg::rsp_type res_w;

   assign fire        = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   assign seed_crc = smbrc_pkg::crc8_byte(
                        smbrc_pkg::crc8_byte(smbrc_pkg::crc8_byte(8'd0, cfg.device_address),
                                             cfg.command_code),
                        cfg.device_address | 8'h01);

   assign limit = (cfg.max_length > MaxBlk) ? MaxBlk : cfg.max_length;
   assign is_ma = (cfg.read_mode == smbrc_pkg::MODE_MA);

   always_comb begin
      cur_pos  = in_first_ff ? 6'd0 : pos_ff;
      cur_crc  = in_first_ff ? seed_crc : crc_ff;
      cur_len  = in_first_ff ? 6'd0 : len_ff;
      cur_low  = in_first_ff ? 8'd0 : low_ff;
      cur_bad  = in_first_ff ? 1'b0 : bad_ff;
      cur_done = in_first_ff ? 1'b0 : done_ff;
      crc_upd  = smbrc_pkg::crc8_byte(cur_crc, in_byte_ff);
      delivered = (cur_len > 6'd2) ? cur_len - 6'd2 : 6'd0;

      pos_in  = cur_pos;
      crc_in  = cur_crc;
      len_in  = cur_len;
      low_in  = cur_low;
      bad_in  = cur_bad;
      done_in = cur_done;
      emit    = 1'b0;
      res_w   = '0;

      if (!cur_done) begin
         if (cfg.read_mode == smbrc_pkg::MODE_WORD) begin
            if (cur_pos < 6'd2) begin
               crc_in         = crc_upd;
               pos_in         = cur_pos + 6'd1;
               emit           = 1'b1;
               res_w.out_byte = in_byte_ff;
               res_w.kind     = smbrc_pkg::KIND_DATA;
            end else begin
               emit                = 1'b1;
               done_in             = 1'b1;
               res_w.kind          = smbrc_pkg::KIND_STATUS;
               res_w.status        = (cur_crc == in_byte_ff) ? smbrc_pkg::STATUS_OK
                                                             : smbrc_pkg::STATUS_PEC_ERR;
               res_w.payload_count = 6'd2;
            end
         end else if (cur_pos == 6'd0) begin
            crc_in = crc_upd;
            if (in_byte_ff == 8'd0 || in_byte_ff > {2'b00, limit}) begin
               emit                = 1'b1;
               done_in             = 1'b1;
               res_w.kind          = smbrc_pkg::KIND_STATUS;
               res_w.status        = smbrc_pkg::STATUS_BAD_LEN;
               res_w.payload_count = 6'd0;
            end else begin
               len_in = in_byte_ff[5:0];
               pos_in = 6'd1;
            end
         end else if (cur_pos <= cur_len) begin
            crc_in = crc_upd;
            pos_in = cur_pos + 6'd1;
            if (is_ma && cur_pos == 6'd1) begin
               low_in = in_byte_ff;
            end else if (is_ma && cur_pos == 6'd2) begin
               bad_in = ({in_byte_ff, cur_low} != cfg.expected_ma_address);
            end else begin
               emit           = 1'b1;
               res_w.out_byte = in_byte_ff;
               res_w.kind     = smbrc_pkg::KIND_DATA;
            end
         end else begin
            emit       = 1'b1;
            done_in    = 1'b1;
            res_w.kind = smbrc_pkg::KIND_STATUS;
            if (is_ma) begin
               res_w.payload_count = delivered;
               if (cur_crc != in_byte_ff) begin
                  res_w.status = smbrc_pkg::STATUS_PEC_ERR;
               end else if (cur_len <= 6'd2) begin
                  res_w.status = smbrc_pkg::STATUS_TOO_SHORT;
               end else if (cur_bad) begin
                  res_w.status = smbrc_pkg::STATUS_ADDR_ERR;
               end else begin
                  res_w.status = smbrc_pkg::STATUS_OK;
               end
            end else begin
               res_w.payload_count = cur_len;
               res_w.status        = (cur_crc == in_byte_ff) ? smbrc_pkg::STATUS_OK
                                                             : smbrc_pkg::STATUS_PEC_ERR;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= 6'd0;
         crc_ff      <= 8'd0;
         len_ff      <= 6'd0;
         low_ff      <= 8'd0;
         bad_ff      <= 1'b0;
         done_ff     <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            pos_ff  <= pos_in;
            crc_ff  <= crc_in;
            len_ff  <= len_in;
            low_ff  <= low_in;
            bad_ff  <= bad_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_byte;
         in_first_ff <= req_first;
      end
   end

   assign res_valid = fire && emit;
   assign res       = res_w;

endmodule
`default_nettype wire

/* src/smbrc_out.sv */
// Result register that holds one checked item until the receiver takes it.
`default_nettype none
module smbrc_out (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               res_valid,
   input  wire smbrc_pkg::rsp_type res,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output smbrc_pkg::rsp_type      rsp
);

   logic               valid_ff, valid_in;
   smbrc_pkg::rsp_type data_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = out_free ? res_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         data_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp        = data_ff;

endmodule
`default_nettype wire

/* src/smbus_read_response_checker.sv */
// Top level of the SMBus read response checker.
//
// Each request on the req_ channel carries one byte received from the bus and a
// flag that marks the first byte of a new read response. The block keeps the
// CRC-8 PEC over the response and passes data bytes on the rsp_ channel as
// payload items, then ends each response with one status item.
// A status item reports ok, bad length, PEC mismatch, address mismatch or too
// short, together with the number of payload bytes delivered.
// The csr_ port writes the mode, address, command, length limit and expected
// manufacturer-access address; the user must write it only while no request is in
// flight; the block does not enforce this. A request passes an input register and
// a result register to rsp_, taking one request per cycle unless the receiver stalls.
// After reset the block is idle and ignores bytes until one marked first.
// When the receiver stalls, the result register holds its item and the input
// register fills, after which req_tready falls until the receiver takes one.
`default_nettype none
module smbus_read_response_checker #(
   parameter int unsigned MAX_BLOCK = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [7:0]                           req_tdata,  // rx_byte
   input  wire logic                                 req_tuser,  // first
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [23:0]                               rsp_tdata,  // out_byte, status, payload_count
   output logic                                      rsp_tuser,  // kind
   input  wire logic                                 csr_we,
   input  wire logic [smbrc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [smbrc_pkg::CsrDataWidth-1:0]   csr_wdata
);

   smbrc_pkg::cfg_type cfg;
   smbrc_pkg::rsp_type res;
   smbrc_pkg::rsp_type rsp;
   logic               res_valid;
   logic               out_free;

   smbrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   smbrc_core #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_first  (req_tuser),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   smbrc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.payload_count, rsp.status, rsp.out_byte};
   assign rsp_tuser = rsp.kind;

endmodule
`default_nettype wire
